@@ design/hmbc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmbc_pkg
// Shared types, codes and helpers of the handheld memory bus controller.
// ----------------------------------------------------------------------------
package hmbc_pkg;

    localparam int ROM_AW       = 20;
    localparam int ROM_CAPACITY = 1 << ROM_AW;
    localparam int IO_AW        = 10;
    localparam int DIV_W        = 25;

    localparam logic [1:0] REQ_READ      = 2'd0;
    localparam logic [1:0] REQ_WRITE     = 2'd1;
    localparam logic [1:0] REQ_LOAD_BOOT = 2'd2;
    localparam logic [1:0] REQ_LOAD_ROM  = 2'd3;

    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;

    localparam logic [3:0] RG_BOOT = 4'd0;
    localparam logic [3:0] RG_EWR  = 4'd1;
    localparam logic [3:0] RG_IWR  = 4'd2;
    localparam logic [3:0] RG_IO   = 4'd3;
    localparam logic [3:0] RG_PAL  = 4'd4;
    localparam logic [3:0] RG_VID  = 4'd5;
    localparam logic [3:0] RG_OAM  = 4'd6;
    localparam logic [3:0] RG_ROM0 = 4'd7;
    localparam logic [3:0] RG_ROM1 = 4'd8;
    localparam logic [3:0] RG_ROM2 = 4'd9;
    localparam logic [3:0] RG_SAVE = 4'd10;
    localparam logic [3:0] RG_NONE = 4'd11;

    localparam logic [IO_AW-1:0] IO_IE      = 10'h200;
    localparam logic [IO_AW-1:0] IO_IE_HI   = 10'h201;
    localparam logic [IO_AW-1:0] IO_IF      = 10'h202;
    localparam logic [IO_AW-1:0] IO_WAITCNT = 10'h204;
    localparam logic [IO_AW-1:0] IO_IME     = 10'h208;

    localparam logic [31:0] BOOT_GUARD_WORD = 32'hE129F000;
    localparam logic [31:0] BOOT_GUARD_HALF = 32'h0000F000;

    typedef struct packed {
        logic             load;
        logic             div_start;
        logic             acc;
        logic             cap;
        logic [1:0]       idx;
        logic             clr;
        logic [IO_AW-1:0] clr_idx;
    } t_cmd;

    typedef struct packed {
        logic       skip;
        logic       need_div;
        logic       div_done;
        logic       is_read;
        logic [1:0] last_idx;
    } t_sts;

    function automatic logic [3:0] region_of(input logic [7:0] rg);
        logic [3:0] code;
        case (rg)
            8'h00: code = RG_BOOT;
            8'h02: code = RG_EWR;
            8'h03: code = RG_IWR;
            8'h04: code = RG_IO;
            8'h05: code = RG_PAL;
            8'h06: code = RG_VID;
            8'h07: code = RG_OAM;
            8'h08, 8'h09: code = RG_ROM0;
            8'h0A, 8'h0B: code = RG_ROM1;
            8'h0C, 8'h0D: code = RG_ROM2;
            8'h0E, 8'h0F: code = RG_SAVE;
            default: code = RG_NONE;
        endcase
        return code;
    endfunction

    function automatic logic [31:0] ones_of(input logic [1:0] nm1);
        logic [31:0] m;
        case (nm1)
            2'd0: m = 32'h0000_00FF;
            2'd1: m = 32'h0000_FFFF;
            default: m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

endpackage

@@ design/handheld_memory_bus_controller.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// handheld_memory_bus_controller
// Region-decoded byte-wide memory bus with wait states and interrupt registers.
// ----------------------------------------------------------------------------
// An access is taken when start is high and busy is low; its result appears on
// the o_ ports for exactly one cycle with o_result_valid and cannot be held off.
// After reset the block stays busy while the IO register file is cleared.
// An item goes from decode straight to done when no memory is touched, and
// otherwise through an access step for each byte, each read byte adding a
// capture step, since every store is one byte wide with one port. ROM reads
// first wait for the offset remainder, which is worked out one bit per cycle.
module handheld_memory_bus_controller (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_req_type,
    input  logic [31:0] i_address,
    input  logic [1:0]  i_access_size,
    input  logic [31:0] i_write_data,
    input  logic        i_is_sequential,
    input  logic [31:0] i_cpu_pc,
    input  logic [15:0] i_raise_flags,
    output logic        o_result_valid,
    output logic [31:0] o_read_data,
    output logic [3:0]  o_access_cycles,
    output logic [15:0] o_irq_enable_out,
    output logic [15:0] o_irq_pending_out,
    output logic        o_irq_master_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [25:0]    r_rom_length;
    hmbc_pkg::t_cmd w_cmd;
    hmbc_pkg::t_sts w_sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rom_length <= 26'd0;
        end else if (psel && penable && pwrite && paddr == 2'd0) begin
            r_rom_length <= pwdata[25:0];
        end
    end

    assign prdata = {6'd0, r_rom_length};
    assign pready = 1'b1;

    hmbc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_busy  (busy),
        .o_valid (o_result_valid)
    );

    hmbc_datapath u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .i_rom_length      (r_rom_length),
        .i_req_type        (i_req_type),
        .i_address         (i_address),
        .i_access_size     (i_access_size),
        .i_write_data      (i_write_data),
        .i_is_sequential   (i_is_sequential),
        .i_cpu_pc          (i_cpu_pc),
        .i_raise_flags     (i_raise_flags),
        .o_read_data       (o_read_data),
        .o_access_cycles   (o_access_cycles),
        .o_irq_enable_out  (o_irq_enable_out),
        .o_irq_pending_out (o_irq_pending_out),
        .o_irq_master_out  (o_irq_master_out)
    );

`ifndef SYNTHESIS
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not raise busy");

    a_valid_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe longer than one cycle");

    a_valid_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> busy)
        else $error("result strobe while idle");

    a_cycles_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (o_access_cycles != 4'd0))
        else $error("zero access cycles in result");
`endif

endmodule

@@ design/hmbc_mod.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmbc_mod
// Restoring remainder unit, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hmbc_mod (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [hmbc_pkg::DIV_W-1:0]  i_dividend,
    input  logic [hmbc_pkg::DIV_W:0]    i_divisor,
    output logic                        o_done,
    output logic [hmbc_pkg::DIV_W-1:0]  o_rem
);

    localparam int CW = $clog2(hmbc_pkg::DIV_W + 1);

    logic                       r_busy, r_done;
    logic [CW-1:0]              r_cnt;
    logic [hmbc_pkg::DIV_W-1:0] r_rem, r_dvd;
    logic [hmbc_pkg::DIV_W:0]   w_trial;

    assign w_trial = {r_rem, r_dvd[hmbc_pkg::DIV_W-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(hmbc_pkg::DIV_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvd <= i_dividend;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[hmbc_pkg::DIV_W-2:0], 1'b0};
            // remainder never exceeds the dividend bits taken so far, so it fits the dividend width
            if (w_trial >= i_divisor) begin
                r_rem <= hmbc_pkg::DIV_W'(w_trial - i_divisor);
            end else begin
                r_rem <= w_trial[hmbc_pkg::DIV_W-1:0];
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

@@ design/hmbc_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmbc_ctrl
// Sequencer: IO clearing pass, decode, ROM offset wait, byte-wise access.
// ----------------------------------------------------------------------------
module hmbc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  hmbc_pkg::t_sts i_sts,
    output hmbc_pkg::t_cmd o_cmd,
    output logic           o_busy,
    output logic           o_valid
);

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_DEC  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_ACC  = 3'd4;
    localparam logic [2:0] S_CAP  = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0]                 r_state, n_state;
    logic [1:0]                 r_idx, n_idx;
    logic [hmbc_pkg::IO_AW-1:0] r_clr, n_clr;

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_clr   = r_clr;
        o_cmd   = '0;
        o_cmd.idx     = r_idx;
        o_cmd.clr_idx = r_clr;
        case (r_state)
            S_CLR: begin
                o_cmd.clr = 1'b1;
                n_clr     = r_clr + 1'b1;
                if (&r_clr) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_idx      = 2'd0;
                    n_state    = S_DEC;
                end
            end
            S_DEC: begin
                if (i_sts.skip) begin
                    n_state = S_DONE;
                end else if (i_sts.need_div) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end else begin
                    n_state = S_ACC;
                end
            end
            S_DIV: begin
                if (i_sts.div_done) n_state = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                if (i_sts.is_read) begin
                    n_state = S_CAP;
                end else if (r_idx == i_sts.last_idx) begin
                    n_state = S_DONE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_CAP: begin
                o_cmd.cap = 1'b1;
                if (r_idx == i_sts.last_idx) begin
                    n_state = S_DONE;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_ACC;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_idx   <= 2'd0;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_clr   <= n_clr;
        end
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = (r_state == S_DONE);

endmodule

@@ design/hmbc_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmbc_datapath
// Item registers, memories, IO side effects, wait states and result.
// ----------------------------------------------------------------------------
module hmbc_datapath (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  hmbc_pkg::t_cmd i_cmd,
    output hmbc_pkg::t_sts o_sts,
    input  logic [25:0]    i_rom_length,
    input  logic [1:0]     i_req_type,
    input  logic [31:0]    i_address,
    input  logic [1:0]     i_access_size,
    input  logic [31:0]    i_write_data,
    input  logic           i_is_sequential,
    input  logic [31:0]    i_cpu_pc,
    input  logic [15:0]    i_raise_flags,
    output logic [31:0]    o_read_data,
    output logic [3:0]     o_access_cycles,
    output logic [15:0]    o_irq_enable_out,
    output logic [15:0]    o_irq_pending_out,
    output logic           o_irq_master_out
);

    localparam int AW = hmbc_pkg::ROM_AW;
    localparam int IW = hmbc_pkg::IO_AW;

    // item registers
    logic [1:0]  r_type;
    logic [31:0] r_addr;
    logic [1:0]  r_nm1;
    logic [31:0] r_data;
    logic [3:0]  r_rg;
    logic [31:0] r_rd;
    logic [3:0]  r_cyc;

    // wait states and interrupt registers
    logic [2:0]  r_save_wait, r_w0n, r_w1n, r_w1s, r_w2n;
    logic [1:0]  r_w0s;
    logic [3:0]  r_w2s;
    logic [15:0] r_ie, r_if;
    logic        r_ime;

    logic [1:0]  w_nm1;
    logic [31:0] w_aligned;
    logic [3:0]  w_rg;
    logic        w_pc_hi;
    logic [3:0]  w_cyc;
    logic [31:0] w_rd_init;

    assign w_nm1     = (i_access_size == hmbc_pkg::SIZE_BYTE) ? 2'd0 :
                       (i_access_size == hmbc_pkg::SIZE_HALF) ? 2'd1 : 2'd3;
    assign w_aligned = i_address & ~{30'd0, w_nm1};
    assign w_rg      = hmbc_pkg::region_of(w_aligned[31:24]);
    assign w_pc_hi   = |i_cpu_pc[31:14];

    always_comb begin
        case (w_rg)
            hmbc_pkg::RG_EWR:  w_cyc = 4'd3;
            hmbc_pkg::RG_ROM0: w_cyc = i_is_sequential ? {2'd0, r_w0s} : {1'b0, r_w0n};
            hmbc_pkg::RG_ROM1: w_cyc = i_is_sequential ? {1'b0, r_w1s} : {1'b0, r_w1n};
            hmbc_pkg::RG_ROM2: w_cyc = i_is_sequential ? r_w2s : {1'b0, r_w2n};
            hmbc_pkg::RG_SAVE: w_cyc = {1'b0, r_save_wait};
            default:           w_cyc = 4'd1;
        endcase
    end

    // fixed answers that need no memory access
    always_comb begin
        w_rd_init = 32'd0;
        if (i_req_type == hmbc_pkg::REQ_READ) begin
            if (w_rg == hmbc_pkg::RG_BOOT && w_pc_hi) begin
                if (w_nm1 == 2'd3)      w_rd_init = hmbc_pkg::BOOT_GUARD_WORD;
                else if (w_nm1 == 2'd1) w_rd_init = hmbc_pkg::BOOT_GUARD_HALF;
                else                    w_rd_init = 32'd0;
            end else if ((w_rg == hmbc_pkg::RG_ROM0 || w_rg == hmbc_pkg::RG_ROM1 ||
                          w_rg == hmbc_pkg::RG_ROM2) && i_rom_length == 26'd0) begin
                w_rd_init = hmbc_pkg::ones_of(w_nm1);
            end
        end
    end

    logic r_pc_hi;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_type  <= i_req_type;
            r_addr  <= i_req_type[1] ? i_address : w_aligned;
            r_nm1   <= w_nm1;
            r_data  <= i_write_data;
            r_rg    <= w_rg;
            r_cyc   <= i_req_type[1] ? 4'd1 : w_cyc;
            r_pc_hi <= w_pc_hi;
        end
    end

    // status towards the sequencer
    logic w_load, w_read, w_write, w_rom, w_vmem, w_rom_empty;

    assign w_load      = r_type[1];
    assign w_read      = (r_type == hmbc_pkg::REQ_READ);
    assign w_write     = (r_type == hmbc_pkg::REQ_WRITE);
    assign w_rom       = (r_rg == hmbc_pkg::RG_ROM0) || (r_rg == hmbc_pkg::RG_ROM1) ||
                         (r_rg == hmbc_pkg::RG_ROM2);
    assign w_vmem      = (r_rg == hmbc_pkg::RG_PAL) || (r_rg == hmbc_pkg::RG_VID) ||
                         (r_rg == hmbc_pkg::RG_OAM);
    assign w_rom_empty = (i_rom_length == 26'd0);

    logic w_div_done;
    logic [hmbc_pkg::DIV_W-1:0] w_rem;

    always_comb begin
        o_sts = '0;
        o_sts.is_read  = w_read;
        o_sts.div_done = w_div_done;
        o_sts.need_div = w_read && w_rom && !w_rom_empty;
        o_sts.last_idx = (w_load || r_rg == hmbc_pkg::RG_SAVE) ? 2'd0 : r_nm1;
        if (w_load) begin
            o_sts.skip = 1'b0;
        end else if (w_read) begin
            o_sts.skip = (r_rg == hmbc_pkg::RG_NONE) ||
                         (r_rg == hmbc_pkg::RG_BOOT && r_pc_hi) ||
                         (w_rom && w_rom_empty);
        end else begin
            o_sts.skip = (r_rg == hmbc_pkg::RG_NONE) || (r_rg == hmbc_pkg::RG_BOOT) ||
                         w_rom || (w_vmem && r_nm1 == 2'd0);
        end
    end

    hmbc_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_addr[hmbc_pkg::DIV_W-1:0]),
        .i_divisor  (i_rom_length),
        .o_done     (w_div_done),
        .o_rem      (w_rem)
    );

    // byte addresses of the current beat
    logic [24:0] w_ba;
    logic [25:0] w_rom_sum;
    logic [16:0] w_vo, w_vid_idx;
    logic [7:0]  w_wbyte;
    logic [15:0] w_half;
    logic [4:0]  w_sh;

    assign w_sh      = {i_cmd.idx, 3'b000};
    assign w_ba      = r_addr[24:0] + {23'd0, i_cmd.idx};
    assign w_rom_sum = {1'b0, w_rem} + {24'd0, i_cmd.idx};
    assign w_vo      = w_ba[16:0];
    assign w_vid_idx = (w_vo >= 17'h18000) ? (w_vo - 17'h08000) : w_vo;
    assign w_wbyte   = 8'(r_data >> w_sh);
    assign w_half    = 16'(r_data >> w_sh);

    logic w_wr_acc;
    assign w_wr_acc = i_cmd.acc && w_write;

    // memories
    logic [7:0] m_boot [16384];
    logic [7:0] m_ewr  [262144];
    logic [7:0] m_iwr  [32768];
    logic [7:0] m_io   [1 << IW];
    logic [7:0] m_pal  [1024];
    logic [7:0] m_vid  [98304];
    logic [7:0] m_oam  [1024];
    logic [7:0] m_rom  [hmbc_pkg::ROM_CAPACITY];
    logic [7:0] m_save [65536];

    logic [7:0] r_q_boot, r_q_ewr, r_q_iwr, r_q_io, r_q_pal, r_q_vid, r_q_oam, r_q_rom,
                r_q_save;

    logic [13:0]   w_boot_idx;
    logic [AW-1:0] w_rom_idx;
    logic [IW-1:0] w_io_idx;
    logic [7:0]    w_io_wd;
    logic          w_io_we;

    assign w_boot_idx = w_load ? r_addr[13:0] : w_ba[13:0];
    assign w_rom_idx  = w_load ? r_addr[AW-1:0] : w_rom_sum[AW-1:0];
    assign w_io_idx   = i_cmd.clr ? i_cmd.clr_idx : w_ba[IW-1:0];
    assign w_io_wd    = i_cmd.clr ? 8'd0 : w_wbyte;
    assign w_io_we    = i_cmd.clr || (w_wr_acc && r_rg == hmbc_pkg::RG_IO);

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc && r_type == hmbc_pkg::REQ_LOAD_BOOT) m_boot[w_boot_idx] <= w_wbyte;
        r_q_boot <= m_boot[w_boot_idx];
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_acc && r_rg == hmbc_pkg::RG_EWR) m_ewr[w_ba[17:0]] <= w_wbyte;
        r_q_ewr <= m_ewr[w_ba[17:0]];
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_acc && r_rg == hmbc_pkg::RG_IWR) m_iwr[w_ba[14:0]] <= w_wbyte;
        r_q_iwr <= m_iwr[w_ba[14:0]];
    end

    always_ff @(posedge i_clk) begin
        if (w_io_we) m_io[w_io_idx] <= w_io_wd;
        r_q_io <= m_io[w_io_idx];
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_acc && r_rg == hmbc_pkg::RG_PAL) m_pal[w_ba[9:0]] <= w_wbyte;
        r_q_pal <= m_pal[w_ba[9:0]];
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_acc && r_rg == hmbc_pkg::RG_VID) m_vid[w_vid_idx] <= w_wbyte;
        r_q_vid <= m_vid[w_vid_idx];
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_acc && r_rg == hmbc_pkg::RG_OAM) m_oam[w_ba[9:0]] <= w_wbyte;
        r_q_oam <= m_oam[w_ba[9:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc && r_type == hmbc_pkg::REQ_LOAD_ROM) m_rom[w_rom_idx] <= w_wbyte;
        r_q_rom <= m_rom[w_rom_idx];
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_acc && r_rg == hmbc_pkg::RG_SAVE) m_save[r_addr[15:0]] <= w_wbyte;
        r_q_save <= m_save[r_addr[15:0]];
    end

    // read assembly
    logic [7:0] w_qbyte;

    always_comb begin
        case (r_rg)
            hmbc_pkg::RG_BOOT: w_qbyte = r_q_boot;
            hmbc_pkg::RG_EWR:  w_qbyte = r_q_ewr;
            hmbc_pkg::RG_IWR:  w_qbyte = r_q_iwr;
            hmbc_pkg::RG_IO:   w_qbyte = r_q_io;
            hmbc_pkg::RG_PAL:  w_qbyte = r_q_pal;
            hmbc_pkg::RG_VID:  w_qbyte = r_q_vid;
            hmbc_pkg::RG_OAM:  w_qbyte = r_q_oam;
            hmbc_pkg::RG_ROM0, hmbc_pkg::RG_ROM1, hmbc_pkg::RG_ROM2: w_qbyte = r_q_rom;
            hmbc_pkg::RG_SAVE: w_qbyte = r_q_save;
            default:           w_qbyte = 8'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rd <= w_rd_init;
        end else if (i_cmd.cap) begin
            if (r_rg == hmbc_pkg::RG_SAVE) begin
                r_rd <= {4{w_qbyte}} & hmbc_pkg::ones_of(r_nm1);
            end else begin
                r_rd <= r_rd | ({24'd0, w_qbyte} << w_sh);
            end
        end
    end

    // IO register side effects; a word write acts at each halfword beat
    logic [IW-1:0] w_off;
    logic          w_io_act;

    assign w_off    = w_ba[IW-1:0];
    assign w_io_act = w_wr_acc && (r_rg == hmbc_pkg::RG_IO);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_save_wait <= 3'd1;
            r_w0n       <= 3'd1;
            r_w0s       <= 2'd2;
            r_w1n       <= 3'd1;
            r_w1s       <= 3'd4;
            r_w2n       <= 3'd1;
            r_w2s       <= 4'd8;
            r_ie        <= 16'd0;
            r_if        <= 16'd0;
            r_ime       <= 1'b0;
        end else if (i_cmd.load) begin
            r_if <= r_if | i_raise_flags;
        end else if (w_io_act) begin
            if (r_nm1 == 2'd0) begin
                if (w_off == hmbc_pkg::IO_IE)    r_ie[7:0]  <= w_wbyte;
                if (w_off == hmbc_pkg::IO_IE_HI) r_ie[15:8] <= w_wbyte;
            end else if (!i_cmd.idx[0]) begin
                case (w_off)
                    hmbc_pkg::IO_IE: r_ie <= w_half;
                    hmbc_pkg::IO_IF: r_if <= r_if & ~w_half;
                    hmbc_pkg::IO_WAITCNT: begin
                        r_save_wait <= {1'b0, w_half[1:0]} + 3'd1;
                        r_w0n       <= {1'b0, w_half[3:2]} + 3'd1;
                        r_w0s       <= w_half[4] ? 2'd1 : 2'd2;
                        r_w1n       <= {1'b0, w_half[6:5]} + 3'd1;
                        r_w1s       <= w_half[7] ? 3'd1 : 3'd4;
                        r_w2n       <= {1'b0, w_half[9:8]} + 3'd1;
                        r_w2s       <= w_half[10] ? 4'd1 : 4'd8;
                    end
                    hmbc_pkg::IO_IME: r_ime <= w_half[0];
                    default: ;
                endcase
            end
        end
    end

    assign o_read_data       = r_rd;
    assign o_access_cycles   = r_cyc;
    assign o_irq_enable_out  = r_ie;
    assign o_irq_pending_out = r_if;
    assign o_irq_master_out  = r_ime;

endmodule

@@ tb/tb_handheld_memory_bus_controller.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_handheld_memory_bus_controller
// Self-checking bench for the region-decoded bus controller.
// ----------------------------------------------------------------------------
// Accesses go in over the start/busy command port. A local model of the memory
// map, the wait states and the interrupt registers predicts every result beat,
// which is checked field by field as it leaves. A directed pass covers the
// decode corners; random traffic then runs under several ROM lengths with
// varying sender gaps. Only bytes already written are ever read back.
// ----------------------------------------------------------------------------
module tb_handheld_memory_bus_controller;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 60;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] addr;
        logic [1:0]  size;
        logic [31:0] data;
        logic        seq;
        logic [31:0] pc;
        logic [15:0] flags;
    } t_bus_req;

    typedef struct packed {
        logic [31:0] rd;
        logic [3:0]  cyc;
        logic [15:0] ie;
        logic [15:0] ifl;
        logic        ime;
    } t_bus_resp;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_req_type = '0;
    logic [31:0] i_address = '0;
    logic [1:0]  i_access_size = '0;
    logic [31:0] i_write_data = '0;
    logic        i_is_sequential = 1'b0;
    logic [31:0] i_cpu_pc = '0;
    logic [15:0] i_raise_flags = '0;
    logic        o_result_valid;
    logic [31:0] o_read_data;
    logic [3:0]  o_access_cycles;
    logic [15:0] o_irq_enable_out;
    logic [15:0] o_irq_pending_out;
    logic        o_irq_master_out;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    handheld_memory_bus_controller dut (.*);

    always #4 i_clk = ~i_clk;

    // model state
    logic [7:0]  io_img [1024];
    logic [7:0]  mem_img [bit [35:0]];
    logic [3:0]  save_ws, w0n, w0s, w1n, w1s, w2n, w2s;
    logic [15:0] ie_q, if_q;
    logic        ime_q;
    logic [25:0] rom_len;

    t_bus_resp due_responses[$];
    int err_cnt = 0, n_items = 0, n_reads = 0, n_writes = 0, n_loads = 0, n_checked = 0;
    int idle_pct = 0;
    int quiet_cycles = 0;

    function automatic logic [3:0] slot_of(input logic [31:0] a, output logic [31:0] idx);
        logic [31:0] o;
        idx = '0;
        case (a[31:24])
            8'h02: begin idx = a & 32'h3FFFF; return hmbc_pkg::RG_EWR; end
            8'h03: begin idx = a & 32'h7FFF;  return hmbc_pkg::RG_IWR; end
            8'h04: begin idx = a & 32'h3FF;   return hmbc_pkg::RG_IO;  end
            8'h05: begin idx = a & 32'h3FF;   return hmbc_pkg::RG_PAL; end
            8'h06: begin
                o = a & 32'h1FFFF;
                if (o >= 32'h18000) o = o - 32'h8000;
                idx = o;
                return hmbc_pkg::RG_VID;
            end
            8'h07: begin idx = a & 32'h3FF;   return hmbc_pkg::RG_OAM; end
            default: return hmbc_pkg::RG_NONE;
        endcase
    endfunction

    function automatic logic [7:0] peek(input logic [3:0] rg, input logic [31:0] idx,
                                        inout bit ok);
        if (rg == hmbc_pkg::RG_IO) return io_img[idx[9:0]];
        if (!mem_img.exists({rg, idx})) begin
            ok = 1'b0;
            return 8'h00;
        end
        return mem_img[{rg, idx}];
    endfunction

    function automatic int unsigned bytes_of(input logic [1:0] size);
        return (size == hmbc_pkg::SIZE_BYTE) ? 1 : (size == hmbc_pkg::SIZE_HALF ? 2 : 4);
    endfunction

    // ok drops when any byte the read needs has never been written
    function automatic logic [31:0] bus_read(input logic [31:0] a, input int unsigned n,
                                             input logic [31:0] pc, output bit ok);
        logic [31:0] v, ones, idx, off;
        logic [3:0]  rg;
        v = '0;
        ok = 1'b1;
        ones = (n == 4) ? 32'hFFFF_FFFF : ((32'd1 << (8 * n)) - 1);
        if (a[31:24] == 8'h00) begin
            if (pc >= 32'h4000)
                return (n == 4) ? hmbc_pkg::BOOT_GUARD_WORD :
                       (n == 2 ? hmbc_pkg::BOOT_GUARD_HALF : 32'h0);
            for (int i = 0; i < n; i++)
                v |= 32'(peek(hmbc_pkg::RG_BOOT, (a + i) & 32'h3FFF, ok)) << (8 * i);
            return v;
        end
        if (a[31:24] >= 8'h08 && a[31:24] <= 8'h0D) begin
            if (rom_len == 0) return ones;
            off = (a & 32'h01FF_FFFF) % {6'd0, rom_len};
            for (int i = 0; i < n; i++)
                v |= 32'(peek(hmbc_pkg::RG_ROM0, (off + i) % hmbc_pkg::ROM_CAPACITY, ok))
                     << (8 * i);
            return v;
        end
        if (a[31:24] == 8'h0E || a[31:24] == 8'h0F)
            return (32'(peek(hmbc_pkg::RG_SAVE, a & 32'hFFFF, ok)) * 32'h0101_0101) & ones;
        for (int i = 0; i < n; i++) begin
            rg = slot_of(a + i, idx);
            if (rg == hmbc_pkg::RG_NONE) return 32'h0;
            v |= 32'(peek(rg, idx, ok)) << (8 * i);
        end
        return v;
    endfunction

    function automatic void io_half_write(input logic [31:0] a, input logic [15:0] v);
        logic [9:0] off;
        off = a[9:0];
        io_img[off] = v[7:0];
        io_img[off + 10'd1] = v[15:8];
        case (off)
            hmbc_pkg::IO_IE:  ie_q = v;
            hmbc_pkg::IO_IF:  if_q = if_q & ~v;
            hmbc_pkg::IO_WAITCNT: begin
                save_ws = {2'b0, v[1:0]} + 4'd1;
                w0n = {2'b0, v[3:2]} + 4'd1;
                w0s = v[4] ? 4'd1 : 4'd2;
                w1n = {2'b0, v[6:5]} + 4'd1;
                w1s = v[7] ? 4'd1 : 4'd4;
                w2n = {2'b0, v[9:8]} + 4'd1;
                w2s = v[10] ? 4'd1 : 4'd8;
            end
            hmbc_pkg::IO_IME: ime_q = v[0];
            default: ;
        endcase
    endfunction

    function automatic void bus_write(input logic [31:0] a, input int unsigned n,
                                      input logic [31:0] v);
        logic [31:0] idx;
        logic [3:0]  rg;
        if (a[31:24] == 8'h0E || a[31:24] == 8'h0F) begin
            mem_img[{hmbc_pkg::RG_SAVE, a & 32'hFFFF}] = v[7:0];
            return;
        end
        if (a[31:24] == 8'h04) begin
            if (n == 1) begin
                io_img[a[9:0]] = v[7:0];
                if (a[9:0] == hmbc_pkg::IO_IE || a[9:0] == hmbc_pkg::IO_IE_HI)
                    ie_q = {io_img[hmbc_pkg::IO_IE_HI], io_img[hmbc_pkg::IO_IE]};
            end else begin
                io_half_write(a, v[15:0]);
                if (n == 4) io_half_write(a + 2, v[31:16]);
            end
            return;
        end
        // byte stores to the video memories are dropped
        if (n == 1 && a[31:24] >= 8'h05 && a[31:24] <= 8'h07) return;
        for (int i = 0; i < n; i++) begin
            rg = slot_of(a + i, idx);
            if (rg == hmbc_pkg::RG_NONE) return;
            mem_img[{rg, idx}] = v[8*i +: 8];
        end
    endfunction

    function automatic logic [3:0] wait_cycles(input logic [31:0] a, input logic seq);
        case (a[31:24])
            8'h02: return 4'd3;
            8'h08, 8'h09: return seq ? w0s : w0n;
            8'h0A, 8'h0B: return seq ? w1s : w1n;
            8'h0C, 8'h0D: return seq ? w2s : w2n;
            8'h0E, 8'h0F: return save_ws;
            default: return 4'd1;
        endcase
    endfunction

    function automatic t_bus_resp bus_access_model(input t_bus_req r);
        t_bus_resp   p;
        int unsigned n;
        logic [31:0] a;
        bit          ok;
        p = '0;
        p.cyc = 4'd1;
        if_q = if_q | r.flags;
        if (r.kind == hmbc_pkg::REQ_LOAD_BOOT) begin
            mem_img[{hmbc_pkg::RG_BOOT, r.addr & 32'h3FFF}] = r.data[7:0];
        end else if (r.kind == hmbc_pkg::REQ_LOAD_ROM) begin
            mem_img[{hmbc_pkg::RG_ROM0, r.addr % hmbc_pkg::ROM_CAPACITY}] = r.data[7:0];
        end else begin
            n = bytes_of(r.size);
            a = r.addr & ~(n - 1);
            p.cyc = wait_cycles(a, r.seq);
            if (r.kind == hmbc_pkg::REQ_READ) p.rd = bus_read(a, n, r.pc, ok);
            else bus_write(a, n, r.data);
        end
        p.ie = ie_q;
        p.ifl = if_q;
        p.ime = ime_q;
        return p;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("MISMATCH %s: expected %h, got %h at %0t", what, want, got, $realtime);
        err_cnt++;
    endtask

    // result beats: the receiver cannot stall, so every strobed cycle is a beat
    always @(posedge i_clk) begin
        t_bus_resp w;
        if (i_rst_n && o_result_valid) begin
            if (due_responses.size() == 0) begin
                report_mismatch("unexpected result beat", 32'h0, o_read_data);
            end else begin
                w = due_responses.pop_front();
                n_checked++;
                if (o_read_data !== w.rd) report_mismatch("read_data", w.rd, o_read_data);
                if (o_access_cycles !== w.cyc)
                    report_mismatch("access_cycles", w.cyc, o_access_cycles);
                if (o_irq_enable_out !== w.ie)
                    report_mismatch("irq_enable", w.ie, o_irq_enable_out);
                if (o_irq_pending_out !== w.ifl)
                    report_mismatch("irq_pending", w.ifl, o_irq_pending_out);
                if (o_irq_master_out !== w.ime)
                    report_mismatch("irq_master", w.ime, o_irq_master_out);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_result_valid) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no beat for %0d cycles", WATCHDOG_LIMIT);
            $display("handheld_memory_bus_controller verification failed");
            $finish;
        end
    end

    // start stays high after acceptance unless the sender decides to gap
    task automatic send_access(input t_bus_req r);
        int unsigned n;
        bit          ok;
        if (r.kind == hmbc_pkg::REQ_READ) begin
            n = bytes_of(r.size);
            void'(bus_read(r.addr & ~(n - 1), n, r.pc, ok));
            if (!ok) r.kind = hmbc_pkg::REQ_WRITE;
        end
        start <= 1'b1;
        i_req_type <= r.kind;
        i_address <= r.addr;
        i_access_size <= r.size;
        i_write_data <= r.data;
        i_is_sequential <= r.seq;
        i_cpu_pc <= r.pc;
        i_raise_flags <= r.flags;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        due_responses.push_back(bus_access_model(r));
        n_items++;
        case (r.kind)
            hmbc_pkg::REQ_READ:  n_reads++;
            hmbc_pkg::REQ_WRITE: n_writes++;
            default:             n_loads++;
        endcase
        if ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        @(posedge i_clk);
        while (due_responses.size() != 0 || busy) @(posedge i_clk);
    endtask

    task automatic set_rom_length(input logic [25:0] v);
        wait_idle();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 2'd0;
        pwdata <= {6'd0, v};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rom_len = v;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    function automatic t_bus_req mk(input logic [1:0] k, input logic [31:0] a,
                                    input logic [1:0] s, input logic [31:0] d,
                                    input logic sq, input logic [31:0] pc,
                                    input logic [15:0] fl);
        return '{kind: k, addr: a, size: s, data: d, seq: sq, pc: pc, flags: fl};
    endfunction

    function automatic logic [31:0] pick_addr();
        logic [7:0]  top;
        logic [23:0] m, off;
        off = 24'($urandom_range(0, 31));
        case ($urandom_range(0, 11))
            0: begin top = 8'h00; m = 24'h3FFF; end
            1: begin top = 8'h02; m = 24'h3FFFF; end
            2: begin top = 8'h03; m = 24'h7FFF; end
            3: begin
                top = 8'h04; m = 24'h3FF;
                case ($urandom_range(0, 7))
                    0: off = 24'h200;  1: off = 24'h201;  2: off = 24'h202;
                    3: off = 24'h203;  4: off = 24'h204;  5: off = 24'h208;
                    6: off = 24'h206;  default: off = 24'($urandom_range(0, 1023));
                endcase
            end
            4: begin top = 8'h05; m = 24'h3FF; end
            5: begin
                top = 8'h06; m = 24'h1FFFF;
                case ($urandom_range(0, 3))
                    0: off = off;
                    1: off = off | 24'h10000;
                    2: off = off | 24'h18000;
                    default: off = off | 24'h1FFE0;
                endcase
            end
            6: begin top = 8'h07; m = 24'h3FF; end
            7, 8: begin top = 8'h08 + 8'($urandom_range(0, 5)); m = 24'hFFFFF; end
            9: begin top = 8'h0E + 8'($urandom_range(0, 1)); m = 24'hFFFF; end
            default: return $urandom;
        endcase
        if ($urandom_range(0, 1)) off = off | (24'($urandom) & ~m);
        return {top, off};
    endfunction

    function automatic t_bus_req random_access();
        t_bus_req r;
        r.addr = pick_addr();
        r.size = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
        r.data = $urandom;
        r.seq = 1'($urandom_range(0, 1));
        r.pc = ($urandom_range(0, 9) < 7) ? 32'($urandom_range(0, 32'h3FFF)) : $urandom;
        r.flags = ($urandom_range(0, 9) < 3) ? 16'($urandom) : 16'h0;
        case ($urandom_range(0, 9))
            0: begin
                r.kind = hmbc_pkg::REQ_LOAD_BOOT;
                r.addr = ($urandom & ~32'h3FFF) | 32'($urandom_range(0, 40));
            end
            1: begin
                r.kind = hmbc_pkg::REQ_LOAD_ROM;
                r.addr = ($urandom_range(0, 7) == 0) ? $urandom :
                         (($urandom & ~32'hFFFFF) | 32'($urandom_range(0, 111)));
            end
            2, 3, 4, 5: r.kind = hmbc_pkg::REQ_READ;
            default: r.kind = hmbc_pkg::REQ_WRITE;
        endcase
        return r;
    endfunction

    task automatic test_reset_state();
        foreach (io_img[i]) io_img[i] = 8'h00;
        save_ws = 4'd1; w0n = 4'd1; w0s = 4'd2; w1n = 4'd1; w1s = 4'd4;
        w2n = 4'd1; w2s = 4'd8;
        ie_q = '0; if_q = '0; ime_q = 1'b0; rom_len = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_rom_length(26'd0);
    endtask

    task automatic test_decode_corners();
        idle_pct = 0;
        for (int i = 0; i < 4; i++)
            send_access(mk(hmbc_pkg::REQ_LOAD_BOOT, 32'hFFFF_C000 | i, 2'd0,
                           32'h11 * (i + 1), 0, 0, 0));
        send_access(mk(hmbc_pkg::REQ_READ, 32'h0000_0000, 2'd2, 0, 0, 32'h100, 0));
        send_access(mk(hmbc_pkg::REQ_READ, 32'h0000_0003, 2'd2, 0, 0, 32'h4000, 0));
        send_access(mk(hmbc_pkg::REQ_READ, 32'h00FF_FFFE, 2'd1, 0, 0, 32'hFFFF_FFFF, 0));
        send_access(mk(hmbc_pkg::REQ_READ, 32'h0000_0001, 2'd0, 0, 0, 32'h8000, 0));
        // no image loaded: ROM reads float high
        send_access(mk(hmbc_pkg::REQ_READ, 32'h0800_0001, 2'd0, 0, 1, 0, 0));
        send_access(mk(hmbc_pkg::REQ_READ, 32'h0A00_0003, 2'd1, 0, 0, 0, 0));
        send_access(mk(hmbc_pkg::REQ_READ, 32'h0DFF_FFFF, 2'd2, 0, 1, 0, 0));
        send_access(mk(hmbc_pkg::REQ_WRITE, 32'h0E00_0010, 2'd2, 32'h1234_56A5, 0, 0, 0));
        send_access(mk(hmbc_pkg::REQ_READ, 32'h0F00_0010, 2'd2, 0, 0, 0, 0));
        send_access(mk(hmbc_pkg::REQ_WRITE, 32'h0600_0000, 2'd0, 32'h77, 0, 0, 0));
        send_access(mk(hmbc_pkg::REQ_WRITE, 32'h0601_8000, 2'd1, 32'hBEEF, 0, 0, 0));
        send_access(mk(hmbc_pkg::REQ_READ, 32'h0601_0000, 2'd1, 0, 0, 0, 0));
        send_access(mk(hmbc_pkg::REQ_WRITE, 32'h0400_0202, 2'd1, 32'h00FF, 0, 0, 16'hFFFF));
        send_access(mk(hmbc_pkg::REQ_WRITE, 32'h0400_0200, 2'd1, 32'h1234, 0, 0, 0));
        send_access(mk(hmbc_pkg::REQ_WRITE, 32'h0400_0201, 2'd0, 32'hAB, 0, 0, 0));
        send_access(mk(hmbc_pkg::REQ_WRITE, 32'h0400_0204, 2'd2, 32'h0001_07FF, 0, 0, 0));
        send_access(mk(hmbc_pkg::REQ_READ, 32'h0C00_0000, 2'd2, 0, 1, 0, 0));
        send_access(mk(hmbc_pkg::REQ_WRITE, 32'h0400_0208, 2'd2, 32'h1, 0, 0, 0));
        send_access(mk(hmbc_pkg::REQ_READ, 32'hFFFF_FFFF, 2'd3, 0, 0, 0, 0));
        send_access(mk(hmbc_pkg::REQ_WRITE, 32'h0200_0020, 2'd2, 32'hDEAD_BEEF, 0, 0, 0));
        send_access(mk(hmbc_pkg::REQ_READ, 32'h02FC_0021, 2'd3, 0, 0, 0, 0));
    endtask

    task automatic test_random_traffic(input logic [25:0] len, input int gap_pct,
                                       input int count);
        set_rom_length(len);
        idle_pct = gap_pct;
        repeat (count) send_access(random_access());
    endtask

    initial begin
        test_reset_state();
        test_decode_corners();
        test_random_traffic(26'd64, 9, 440);
        test_random_traffic(26'd4, 83, 440);
        test_random_traffic(26'h200_0000, 0, 440);
        test_random_traffic(26'd100, 0, 440);
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("covered %0d accesses (%0d reads, %0d writes, %0d loads), %0d results checked",
                 n_items, n_reads, n_writes, n_loads, n_checked);
        $display("ROM lengths 0, 4, 64, 100 and 2^25 with sender gaps off, light and heavy");
        if (err_cnt == 0 && due_responses.size() == 0) begin
            $display("handheld_memory_bus_controller verification clean");
        end else begin
            $display("%0d mismatches, %0d results outstanding", err_cnt, due_responses.size());
            $display("handheld_memory_bus_controller verification failed");
        end
        $finish;
    end

endmodule

@@ handheld_memory_bus_controller.f @@
design/hmbc_pkg.sv
design/hmbc_mod.sv
design/hmbc_ctrl.sv
design/hmbc_datapath.sv
design/handheld_memory_bus_controller.sv
tb/tb_handheld_memory_bus_controller.sv
